// ===== rtl/jgr_pkg.sv =====
// Shared types and constants for the Julian-to-Gregorian timestamp rebase.
package jgr_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_REBASE = 1'b1;

  localparam logic [36:0] DAY_US     = 37'd86400000000;
  localparam logic [63:0] CENTURY_US = 64'd3155760000000000;

  // century divided by 2^13, and floor(2^57 / CENTURY_HI) for the quotient estimate
  localparam logic [38:0] CENTURY_HI  = 39'd385224609375;
  localparam logic [18:0] CENTURY_RCP = 19'd374106;

  // quotient bits of a 64-bit distance divided by one century
  localparam int unsigned QW = 13;

  typedef struct packed {
    logic        op;
    logic [3:0]  idx;
    logic [63:0] value;
    logic [40:0] shift;
  } jgr_item_t;

  function automatic logic [63:0] sext_shift(input logic [40:0] v);
    return {{23{v[40]}}, v};
  endfunction

endpackage

// ===== rtl/julian_gregorian_micros_rebase.sv =====
// Top level of the Julian-to-Gregorian microsecond timestamp rebase.
// A load request writes one switch/shift entry of the table. A rebase request first
// compares the timestamp with the final switch and is done when it is at or after it;
// inside the table range it reads one table RAM entry per entry visited; before the first
// switch and within one century of entry 1 it also reads entry 1; for longer distances the
// century count comes from a reciprocal estimate and one correction step. A two-entry queue
// lets requests be taken while the back end works, and the result register lets the back
// end move on while a result waits.
module julian_gregorian_micros_rebase #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [3:0]  entry_index_i,
  input  logic [63:0] switch_value_i,
  input  logic [40:0] shift_value_i,
  input  logic [63:0] timestamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] rebased_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = ($clog2(TABLE_DEPTH + 1) > 5) ? $clog2(TABLE_DEPTH + 1) : 5;

  logic [4:0]         entry_count_q;
  logic [CW-1:0]      cnt_ext, n_eff;
  logic [AW-1:0]      last_idx;
  logic               q_valid, q_pop;
  jgr_pkg::jgr_item_t q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= 5'd2;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    cnt_ext = CW'(entry_count_q);
    if (cnt_ext < CW'(2)) begin
      n_eff = CW'(2);
    end else if (cnt_ext > CW'(TABLE_DEPTH)) begin
      n_eff = CW'(TABLE_DEPTH);
    end else begin
      n_eff = cnt_ext;
    end
    last_idx = AW'(n_eff - CW'(1));
  end

  jgr_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .entry_index_i  (entry_index_i),
    .switch_value_i (switch_value_i),
    .shift_value_i  (shift_value_i),
    .timestamp_i    (timestamp_i),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  jgr_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .last_idx_i  (last_idx),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rebased_o   (rebased_o)
  );

endmodule

// ===== rtl/jgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module jgr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/jgr_front.sv =====
// Front end: accept requests, drop out-of-range loads, queue the rest.
module jgr_front #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic [3:0]         entry_index_i,
  input  logic [63:0]        switch_value_i,
  input  logic [40:0]        shift_value_i,
  input  logic [63:0]        timestamp_i,
  output logic               q_valid_o,
  output jgr_pkg::jgr_item_t q_item_o,
  input  logic               q_pop_i
);

  localparam int unsigned IW = ($clog2(TABLE_DEPTH + 1) > 5) ? $clog2(TABLE_DEPTH + 1) : 5;

  jgr_pkg::jgr_item_t mem_q [2];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               keep, push;
  jgr_pkg::jgr_item_t item;

  assign in_ready_o = (cnt_q != 2'd2);
  assign keep = (operation_i == jgr_pkg::OP_REBASE) ||
                (IW'(entry_index_i) < IW'(TABLE_DEPTH));
  assign push = in_valid_i && in_ready_o && keep;

  always_comb begin
    item.op    = operation_i;
    item.idx   = entry_index_i;
    item.value = (operation_i == jgr_pkg::OP_LOAD) ? switch_value_i : timestamp_i;
    item.shift = shift_value_i;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_ptr_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> cnt_q != 2'd0)
    else $error("pop from empty queue");

endmodule

// ===== rtl/jgr_back.sv =====
// Back end: table storage, switch search, century extrapolation and result register.
module jgr_back #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  input  jgr_pkg::jgr_item_t             q_item_i,
  output logic                           q_pop_o,
  input  logic [$clog2(TABLE_DEPTH)-1:0] last_idx_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [63:0]                    rebased_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned QW = jgr_pkg::QW;
  localparam int unsigned PW = QW + 37;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LAST  = 4'd1;
  localparam logic [3:0] S_FIRST = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_SW1   = 4'd4;
  localparam logic [3:0] S_EST   = 4'd5;
  localparam logic [3:0] S_PROD  = 4'd6;
  localparam logic [3:0] S_CORR  = 4'd7;
  localparam logic [3:0] S_CEIL  = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]    state_q, state_d;
  logic          out_valid_q, out_valid_d;
  logic [63:0]   rebased_q, rebased_d;
  logic [63:0]   t_q, t_d;
  logic [63:0]   res_q, res_d;
  logic [40:0]   sh0_q, sh0_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [63:0]   rem_q, rem_d;
  logic [QW-1:0] qf_q, qf_d;
  logic [51:0]   pc_q, pc_d;
  logic          nz_q, nz_d;
  logic [QW-1:0] e_q, e_d;
  logic [PW-1:0] prod_q, prod_d;

  logic          wr_en;
  logic [AW-1:0] raddr;
  logic [104:0]  rdata;
  logic [63:0]   sw_rd;
  logic [40:0]   sh_rd;
  logic          t_lt;
  logic [63:0]   diff;
  logic [50:0]   dh;
  logic [44:0]   est;
  logic [51:0]   r_raw;
  logic [QW-1:0] q_ceil, s_val;

  jgr_ram #(.WIDTH(105), .DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AW'(q_item_i.idx)),
    .wdata_i ({q_item_i.value, q_item_i.shift}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign sw_rd  = rdata[104:41];
  assign sh_rd  = rdata[40:0];
  assign t_lt   = $signed(t_q) < $signed(sw_rd);
  assign diff   = sw_rd - t_q;
  assign dh     = rem_q[63:13];
  assign est    = 45'(dh[50:25]) * 45'(jgr_pkg::CENTURY_RCP);
  assign r_raw  = {1'b0, dh} - pc_q;
  assign q_ceil = qf_q + QW'(nz_q);
  assign s_val  = q_ceil - QW'(2);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rebased_d   = rebased_q;
    t_d         = t_q;
    res_d       = res_q;
    sh0_d       = sh0_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    qf_d        = qf_q;
    pc_d        = pc_q;
    nz_d        = nz_q;
    e_d         = e_q;
    prod_d      = prod_q;
    wr_en       = 1'b0;
    q_pop_o     = 1'b0;
    raddr       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.op == jgr_pkg::OP_LOAD) begin
            wr_en = 1'b1;
          end else begin
            t_d     = q_item_i.value;
            raddr   = last_idx_i;
            state_d = S_LAST;
          end
        end
      end
      S_LAST: begin
        if (!t_lt) begin
          res_d   = t_q;
          state_d = S_OUT;
        end else begin
          raddr   = '0;
          state_d = S_FIRST;
        end
      end
      S_FIRST: begin
        sh0_d = sh_rd;
        if (t_lt) begin
          raddr   = AW'(1);
          state_d = S_SW1;
        end else if (last_idx_i == AW'(1)) begin
          res_d   = t_q + jgr_pkg::sext_shift(sh_rd);
          state_d = S_OUT;
        end else begin
          idx_d   = last_idx_i - AW'(1);
          raddr   = last_idx_i - AW'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!t_lt) begin
          res_d   = t_q + jgr_pkg::sext_shift(sh_rd);
          state_d = S_OUT;
        end else if (idx_q == AW'(1)) begin
          res_d   = t_q + jgr_pkg::sext_shift(sh0_q);
          state_d = S_OUT;
        end else begin
          idx_d = idx_q - AW'(1);
          raddr = idx_q - AW'(1);
        end
      end
      S_SW1: begin
        if (!t_lt || diff <= jgr_pkg::CENTURY_US) begin
          res_d   = t_q + jgr_pkg::sext_shift(sh0_q);
          state_d = S_OUT;
        end else begin
          rem_d   = diff;
          state_d = S_EST;
        end
      end
      S_EST: begin
        qf_d    = est[44:32];
        state_d = S_PROD;
      end
      S_PROD: begin
        pc_d    = 52'(qf_q) * 52'(jgr_pkg::CENTURY_HI);
        state_d = S_CORR;
      end
      S_CORR: begin
        if (r_raw >= 52'(jgr_pkg::CENTURY_HI)) begin
          qf_d = qf_q + QW'(1);
          nz_d = (r_raw != 52'(jgr_pkg::CENTURY_HI)) || (rem_q[12:0] != 13'd0);
        end else begin
          nz_d = (r_raw != 52'd0) || (rem_q[12:0] != 13'd0);
        end
        state_d = S_CEIL;
      end
      S_CEIL: begin
        e_d     = s_val - (s_val >> 2);
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = PW'(e_q) * PW'(jgr_pkg::DAY_US);
        state_d = S_FIN;
      end
      S_FIN: begin
        res_d   = t_q + 64'(prod_q) + jgr_pkg::sext_shift(sh0_q);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          rebased_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rebased_q <= rebased_d;
    t_q       <= t_d;
    res_q     <= res_d;
    sh0_q     <= sh0_d;
    idx_q     <= idx_d;
    rem_q     <= rem_d;
    qf_q      <= qf_d;
    pc_q      <= pc_d;
    nz_q      <= nz_d;
    e_q       <= e_d;
    prod_q    <= prod_d;
  end

  assign out_valid_o = out_valid_q;
  assign rebased_o   = rebased_q;

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> state_q == S_IDLE)
    else $error("table write outside idle");
  a_est_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CORR |-> pc_q <= {1'b0, dh})
    else $error("century estimate too high");
  a_ceil_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CEIL |-> q_ceil >= QW'(2))
    else $error("century count too small");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the Julian-to-Gregorian microsecond timestamp rebase block.
module tb_top;

  localparam logic [63:0] DAY     = 64'd86400000000;
  localparam logic [63:0] CENTURY = 64'd3155760000000000;
  localparam int          DEPTH   = 16;
  localparam int          SETTLE  = 60;
  localparam longint      LIMIT   = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        operation_i = jgr_pkg::OP_LOAD;
  logic [3:0]  entry_index_i = '0;
  logic [63:0] switch_value_i = '0;
  logic [40:0] shift_value_i = '0;
  logic [63:0] timestamp_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] rebased_o;

  julian_gregorian_micros_rebase dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_ready_o, .operation_i,
    .entry_index_i, .switch_value_i, .shift_value_i, .timestamp_i, .out_valid_o,
    .out_ready_i, .rebased_o
  );

  // predictor state
  logic [63:0] switch_tab [DEPTH];
  logic [63:0] shift_tab  [DEPTH];
  logic [4:0]  count_reg = 5'd2;
  logic [63:0] rebased_q [$];

  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_len = 0;
  int     errors = 0;
  int     n_requests = 0;
  int     n_rebased = 0;
  longint cycles = 0;

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      out_ready_i <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    $display("mismatch %s: expected %h got %h at cycle %0d", what, exp_v, got_v, cycles);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rebased_q.size() == 0) begin
        report_mismatch("unexpected result", '0, rebased_o);
      end else begin
        logic [63:0] exp_v;
        exp_v = rebased_q.pop_front();
        n_rebased++;
        if (rebased_o !== exp_v) report_mismatch("rebased", exp_v, rebased_o);
      end
    end
  end

  function automatic int active_entries();
    if (count_reg < 2) return 2;
    if (count_reg > DEPTH) return DEPTH;
    return int'(count_reg);
  endfunction

  function automatic logic [63:0] rebase_timestamp(input logic [63:0] t);
    int          n;
    int          i;
    logic [63:0] span;
    logic [63:0] q;
    logic [63:0] s;
    logic [63:0] d;
    n = active_entries();
    if (!($signed(t) < $signed(switch_tab[n-1]))) return t;
    if ($signed(t) < $signed(switch_tab[0])) begin
      d = 64'd2;
      if ($signed(t) < $signed(switch_tab[1])) begin
        span = switch_tab[1] - t;
        if (span > CENTURY) begin
          q = span / CENTURY + ((span % CENTURY) != 0 ? 64'd1 : 64'd0);
          s = q - 64'd2;
          d = 64'd2 + s - s / 64'd4;
        end
      end
      return t + d * DAY + shift_tab[0] - 64'd2 * DAY;
    end
    i = n - 1;
    while (i > 0 && $signed(t) < $signed(switch_tab[i])) i--;
    return t + shift_tab[i];
  endfunction

  task automatic send_request(input logic op, input logic [3:0] idx, input logic [63:0] sw,
                              input logic [40:0] sh, input logic [63:0] ts);
    int idle;
    idle = 0;
    while ($urandom_range(99) < send_idle_pct) idle++;
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    entry_index_i  <= idx;
    switch_value_i <= sw;
    shift_value_i  <= sh;
    timestamp_i    <= ts;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_requests++;
    if (op == jgr_pkg::OP_LOAD) begin
      switch_tab[idx] = sw;
      shift_tab[idx]  = {{23{sh[40]}}, sh};
    end else begin
      rebased_q = {rebased_q, rebase_timestamp(ts)};
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (rebased_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_entry_count(input logic [4:0] v);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    count_reg = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [40:0] rand_shift();
    return 41'({$urandom, $urandom});
  endfunction

  // style 0: full range, 1: clustered, 2: clustered unsorted
  task automatic load_table(input int style);
    longint      vals [$];
    logic [63:0] base;
    base = rand64();
    for (int i = 0; i < DEPTH; i++) begin
      if (style == 0) vals = {vals, longint'(rand64())};
      else vals = {vals, longint'(base + {$urandom_range(3), $urandom})};
    end
    if (style != 2) vals.sort();
    for (int i = 0; i < DEPTH; i++)
      send_request(jgr_pkg::OP_LOAD, 4'(i), vals[i], rand_shift(), '0);
  endtask

  function automatic logic [63:0] pick_timestamp();
    int          n;
    int          k;
    logic [63:0] off;
    n = active_entries();
    k = $urandom_range(n - 1);
    off = 64'($signed($urandom_range(2000)) - 1000);
    case ($urandom_range(6))
      0: return rand64();
      1: return switch_tab[k] + off;
      2: return switch_tab[k] - 64'd1;
      3: return switch_tab[0] - CENTURY * 64'($urandom_range(40)) + off;
      4: return $urandom_range(1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      5: return switch_tab[1] - CENTURY * 64'($urandom_range(5000)) + off;
      default: return switch_tab[k] + {$urandom_range(7), $urandom};
    endcase
  endfunction

  task automatic test_directed();
    logic [63:0] sw [DEPTH];
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < DEPTH; i++) sw[i] = 64'hFFF0_0000_0000_0000 + 64'(i) * 64'd1000000000;
    for (int i = 0; i < DEPTH; i++) begin
      logic [40:0] sh;
      sh = (i == 0) ? 41'h100_0000_0000 : (i == 1) ? 41'h0FF_FFFF_FFFF : rand_shift();
      send_request(jgr_pkg::OP_LOAD, 4'(i), sw[i], sh, '0);
    end
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, 64'h8000_0000_0000_0000);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[1]);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[1] - 64'd1);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[0]);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[0] - 64'd1);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[1] - CENTURY);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[1] - CENTURY - 64'd1);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[1] - 64'd5 * CENTURY);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[1] - 64'd6 * CENTURY - 64'd1);
    set_entry_count(5'd16);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[15]);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[15] - 64'd1);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[7] + 64'd3);
    // unsorted switches and far-out-of-range count
    send_request(jgr_pkg::OP_LOAD, 4'd3, sw[14], rand_shift(), '0);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[14] - 64'd1);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[5]);
    set_entry_count(5'd31);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[10]);
    set_entry_count(5'd0);
    send_request(jgr_pkg::OP_REBASE, '0, '0, '0, sw[0] + 64'd5);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [4:0] count, input int style, input int items);
    set_entry_count(count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    load_table(style);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 8) begin
        logic [3:0] idx;
        idx = 4'($urandom_range(DEPTH - 1));
        send_request(jgr_pkg::OP_LOAD, idx, $urandom_range(3) == 0 ? rand64() : switch_tab[idx],
                     rand_shift(), rand64());
      end else begin
        send_request(jgr_pkg::OP_REBASE, 4'($urandom), rand64(), rand_shift(), pick_timestamp());
      end
    end
  endtask

  task automatic test_backpressure();
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 400;
    for (int i = 0; i < 40; i++)
      send_request(jgr_pkg::OP_REBASE, '0, '0, '0, pick_timestamp());
  endtask

  initial begin
    logic [4:0] counts [10];
    int         idle_set [4];
    int         stall_set [4];
    counts = '{5'd2, 5'd16, 5'd1, 5'd9, 5'd17, 5'd3, 5'd31, 5'd15, 5'd0, 5'd12};
    idle_set = '{0, 73, 0, 21};
    stall_set = '{0, 0, 73, 21};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    for (int p = 0; p < 10; p++)
      test_random_phase(idle_set[p % 4], stall_set[p % 4], counts[p], p % 3, 126);
    test_backpressure();
    test_random_phase(0, 0, 5'($urandom_range(2, 16)), 1, 40);
    drain();
    $display("covered %0d requests and %0d rebased results over %0d cycles",
             n_requests, n_rebased, cycles);
    $display("entry counts 0..31 incl. out of range, sorted and unsorted tables, stalls");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
